>>> src/spit_pkg.sv
// ============================================================================
// spit_pkg: shared types and constants for the swipe period image trigger
// Holds the register map, the reset values of the registers and the
// configuration and result bundles that travel between the modules.
// ============================================================================
package spit_pkg;

  // Register indexes on the configuration port (byte address is 4 * index).
  typedef enum logic [2:0] {
    REG_UPPER_THRESHOLD  = 3'd0,
    REG_LOWER_THRESHOLD  = 3'd1,
    REG_IDLE_LIMIT       = 3'd2,
    REG_IMAGE_COLUMNS    = 3'd3,
    REG_MODE_Z_THRESHOLD = 3'd4,
    REG_MODE_Z_RUN       = 3'd5
  } reg_index_t;

  // Reset values of the registers.
  localparam logic signed [7:0] UPPER_THRESHOLD_RESET  = 8'sd126;
  localparam logic signed [7:0] LOWER_THRESHOLD_RESET  = -8'sd126;
  localparam logic [15:0]       IDLE_LIMIT_RESET       = 16'd800;
  localparam logic [7:0]        IMAGE_COLUMNS_RESET    = 8'd15;
  localparam logic signed [7:0] MODE_Z_THRESHOLD_RESET = 8'sd100;
  localparam logic [7:0]        MODE_Z_RUN_RESET       = 8'd10;

  // Current register contents, as seen by the datapath.
  typedef struct packed {
    logic signed [7:0] upper_threshold;
    logic signed [7:0] lower_threshold;
    logic [15:0]       idle_limit;
    logic [7:0]        image_columns;
    logic signed [7:0] mode_z_threshold;
    logic [7:0]        mode_z_run;
  } cfg_t;

  // One result word.
  typedef struct packed {
    logic show_image;
    logic swing_right;
    logic swing_left;
    logic idle;
    logic change_mode;
  } result_t;

endpackage

>>> src/swipe_period_image_trigger.sv
// ============================================================================
// swipe_period_image_trigger: swing period tracker and image start trigger
// Measures left and right swing periods from x samples, pulses the image
// start point within each swing and watches z for a mode change while idle.
//
//   port group     dir   handshake         payload
//   in  word       in    in_valid/ready    accel_x, accel_z
//   out word       out   out_valid/ready   show_image, swing_right, swing_left,
//                                          idle, change_mode
//   config         in    APB psel/penable  paddr, pwdata, prdata
//
// One word per clock while the output is not stalled; a result passes from the
// input register through the decision logic into the output register.
// The swing state updates as a word moves from input to output register.
// A stalled output holds the pipeline; in_ready drops only when both the
// input and output registers are full and out_ready is low.
// Reset (rst, synchronous) empties the pipeline and loads register defaults.
// ============================================================================
module swipe_period_image_trigger #(
  parameter int COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [7:0] accel_x,
  input  logic signed [7:0] accel_z,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              show_image,
  output logic              swing_right,
  output logic              swing_left,
  output logic              idle,
  output logic              change_mode
);
  import spit_pkg::*;

  cfg_t              cfg;
  result_t           result_next;
  result_t           result;
  logic              full;
  logic signed [7:0] x_reg;
  logic signed [7:0] z_reg;
  logic              advance;

  spit_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  spit_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step    (advance),
    .accel_x (x_reg),
    .accel_z (z_reg),
    .result  (result_next)
  );

  // The held word moves on whenever the output register is free or drains.
  assign advance  = full && (!out_valid || out_ready);
  assign in_ready = !full || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_reg <= accel_x;
      z_reg <= accel_z;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign show_image  = result.show_image;
  assign swing_right = result.swing_right;
  assign swing_left  = result.swing_left;
  assign idle        = result.idle;
  assign change_mode = result.change_mode;

  // Input stalls only with both registers full and the output blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (full && out_valid && !out_ready))
    else $error("input stalled without a blocked pipeline");

  // A new output word always comes from a held input word.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(full))
    else $error("output word appeared without an input word");

  // The image starts only inside an active swing; mode change only while idle.
  a_show_in_swing: assert property (@(posedge clk) disable iff (rst)
    out_valid && show_image |-> (swing_right || swing_left))
    else $error("show pulse outside any swing");

  a_change_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && change_mode |-> idle)
    else $error("mode change while not idle");

endmodule

>>> src/spit_cfg_regs.sv
// ============================================================================
// spit_cfg_regs: configuration register file
// APB-style write and read access to the six trigger registers.
// ============================================================================
module spit_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output spit_pkg::cfg_t cfg
);
  import spit_pkg::*;

  logic       wr_en;
  logic [2:0] index;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign index  = paddr[4:2];

  // Register writes; addresses past the map are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.upper_threshold  <= UPPER_THRESHOLD_RESET;
      cfg.lower_threshold  <= LOWER_THRESHOLD_RESET;
      cfg.idle_limit       <= IDLE_LIMIT_RESET;
      cfg.image_columns    <= IMAGE_COLUMNS_RESET;
      cfg.mode_z_threshold <= MODE_Z_THRESHOLD_RESET;
      cfg.mode_z_run       <= MODE_Z_RUN_RESET;
    end else if (wr_en) begin
      unique case (index)
        REG_UPPER_THRESHOLD:  cfg.upper_threshold  <= pwdata[7:0];
        REG_LOWER_THRESHOLD:  cfg.lower_threshold  <= pwdata[7:0];
        REG_IDLE_LIMIT:       cfg.idle_limit       <= pwdata[15:0];
        REG_IMAGE_COLUMNS:    cfg.image_columns    <= pwdata[7:0];
        REG_MODE_Z_THRESHOLD: cfg.mode_z_threshold <= pwdata[7:0];
        REG_MODE_Z_RUN:       cfg.mode_z_run       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back the raw register bits.
  always_comb begin
    unique case (index)
      REG_UPPER_THRESHOLD:  prdata = {24'd0, cfg.upper_threshold};
      REG_LOWER_THRESHOLD:  prdata = {24'd0, cfg.lower_threshold};
      REG_IDLE_LIMIT:       prdata = {16'd0, cfg.idle_limit};
      REG_IMAGE_COLUMNS:    prdata = {24'd0, cfg.image_columns};
      REG_MODE_Z_THRESHOLD: prdata = {24'd0, cfg.mode_z_threshold};
      REG_MODE_Z_RUN:       prdata = {24'd0, cfg.mode_z_run};
      default:              prdata = 32'd0;
    endcase
  end

endmodule

>>> src/spit_core.sv
// ============================================================================
// spit_core: swing tracking state and per-sample decision logic
// Holds the swing counters, periods and z run, and works out one result
// word from one sample in a single pass of logic.
// ============================================================================
module spit_core #(
  parameter int COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  spit_pkg::cfg_t    cfg,
  input  logic              step,
  input  logic signed [7:0] accel_x,
  input  logic signed [7:0] accel_z,
  output spit_pkg::result_t result
);
  import spit_pkg::*;

  // Compare width that holds a count, the idle limit and twice the columns.
  localparam int EW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [COUNT_BITS-1:0] LEFT_COUNT_RESET =
    COUNT_BITS'(32'(IDLE_LIMIT_RESET) + 32'd1);

  logic signed [7:0]       previous_x;
  logic                    right_active;
  logic                    left_active;
  logic [COUNT_BITS-1:0]   right_count;
  logic [COUNT_BITS-1:0]   left_count;
  logic [COUNT_BITS-1:0]   right_period;
  logic [COUNT_BITS-1:0]   left_period;
  logic [7:0]              z_run_count;

  logic                    right_active_next;
  logic                    left_active_next;
  logic [COUNT_BITS-1:0]   right_step;
  logic [COUNT_BITS-1:0]   left_step;
  logic [COUNT_BITS-1:0]   right_count_next;
  logic [COUNT_BITS-1:0]   left_count_next;
  logic [COUNT_BITS-1:0]   right_period_next;
  logic [COUNT_BITS-1:0]   left_period_next;
  logic [7:0]              z_run_count_next;
  logic [7:0]              z_run_inc;
  logic                    right_start;
  logic                    left_start;
  logic                    show_right;
  logic                    show_left;
  logic                    idle_now;
  logic                    change_now;

  // True when a count sits at the show point of its period. A period
  // shorter than twice the column count never fires.
  function automatic logic hits_target(input logic [COUNT_BITS-1:0] count,
                                       input logic [COUNT_BITS-1:0] period,
                                       input logic [7:0]            columns);
    logic [EW-1:0] off;
    logic [EW-1:0] per;
    logic [EW-1:0] target;
    off    = EW'({columns, 1'b0});
    per    = EW'(period);
    target = (per - off) >> 1;
    return (per >= off) && (EW'(count) == target);
  endfunction

  // Rightward swing: start on a falling crossing of the upper threshold,
  // stop once x drops below the lower threshold.
  always_comb begin
    right_start = (accel_x < cfg.upper_threshold) && (previous_x >= cfg.upper_threshold);
    if (right_start) begin
      right_active_next = 1'b1;
    end else if (accel_x < cfg.lower_threshold) begin
      right_active_next = 1'b0;
    end else begin
      right_active_next = right_active;
    end
    right_step = right_start ? '0 : right_count;
    if (right_active_next) begin
      right_step = right_step + COUNT_BITS'(1);
    end
    show_right = right_active_next && hits_target(right_step, right_period, cfg.image_columns);
  end

  // Leftward swing: start on a rising crossing of the lower threshold,
  // stop once x rises above the upper threshold.
  always_comb begin
    left_start = (accel_x > cfg.lower_threshold) && (previous_x <= cfg.lower_threshold);
    if (left_start) begin
      left_active_next = 1'b1;
    end else if (accel_x > cfg.upper_threshold) begin
      left_active_next = 1'b0;
    end else begin
      left_active_next = left_active;
    end
    left_step = left_start ? '0 : left_count;
    if (left_active_next) begin
      left_step = left_step + COUNT_BITS'(1);
    end
    show_left = left_active_next && hits_target(left_step, left_period, cfg.image_columns);
  end

  // Idle detection and the z run toward a mode change.
  always_comb begin
    idle_now = (EW'(right_step) > EW'(cfg.idle_limit)) ||
               (EW'(left_step) > EW'(cfg.idle_limit));
    z_run_inc        = z_run_count + 8'd1;
    z_run_count_next = z_run_count;
    change_now       = 1'b0;
    if (idle_now) begin
      if (accel_z >= cfg.mode_z_threshold) begin
        z_run_count_next = z_run_inc;
        change_now       = (z_run_inc == cfg.mode_z_run);
      end else begin
        z_run_count_next = 8'd0;
      end
    end
  end

  // A stopped, nonzero count becomes its direction's period.
  always_comb begin
    right_count_next  = right_step;
    right_period_next = right_period;
    if (!right_active_next && (right_step != '0)) begin
      right_period_next = right_step;
      right_count_next  = '0;
    end
    left_count_next  = left_step;
    left_period_next = left_period;
    if (!left_active_next && (left_step != '0)) begin
      left_period_next = left_step;
      left_count_next  = '0;
    end
  end

  always_comb begin
    result.show_image  = show_right || show_left;
    result.swing_right = right_active_next;
    result.swing_left  = left_active_next;
    result.idle        = idle_now;
    result.change_mode = change_now;
  end

  // State update, once per processed sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_x   <= 8'sd0;
      right_active <= 1'b0;
      left_active  <= 1'b1;
      right_count  <= '0;
      left_count   <= LEFT_COUNT_RESET;
      right_period <= '0;
      left_period  <= '0;
      z_run_count  <= 8'd0;
    end else if (step) begin
      previous_x   <= accel_x;
      right_active <= right_active_next;
      left_active  <= left_active_next;
      right_count  <= right_count_next;
      left_count   <= left_count_next;
      right_period <= right_period_next;
      left_period  <= left_period_next;
      z_run_count  <= z_run_count_next;
    end
  end

  // An inactive swing always leaves its count cleared.
  a_right_cleared: assert property (@(posedge clk) disable iff (rst)
    !right_active |-> (right_count == '0))
    else $error("right count nonzero while inactive");

  a_left_cleared: assert property (@(posedge clk) disable iff (rst)
    !left_active |-> (left_count == '0))
    else $error("left count nonzero while inactive");

  // The z run only moves while idle.
  a_z_run_idle: assert property (@(posedge clk) disable iff (rst)
    step && !idle_now |=> $stable(z_run_count))
    else $error("z run changed outside idle");

endmodule

>>> tb/swing_trigger_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// swing_trigger_checker: result predictor and scoreboard for the swipe trigger
// Watches the configuration port and both word channels. It keeps its own
// copy of the settings and of the swing state, predicts one result word for
// every accepted input word, and compares each output word with the oldest
// prediction that is still waiting.
// ============================================================================
module swing_trigger_checker #(
  parameter int COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic signed [7:0] accel_x,
  input  logic signed [7:0] accel_z,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              show_image,
  input  logic              swing_right,
  input  logic              swing_left,
  input  logic              idle,
  input  logic              change_mode,
  output int                mismatch_total,
  output int                words_in_flight
);
  import spit_pkg::*;

  // Settings as last written on the configuration port.
  logic signed [7:0] upper_level;
  logic signed [7:0] lower_level;
  logic [15:0]       idle_limit;
  logic [7:0]        columns;
  logic signed [7:0] z_level;
  logic [7:0]        z_run_target;

  // Swing state.
  logic signed [7:0]     last_x;
  logic                  right_on;
  logic                  left_on;
  logic [COUNT_BITS-1:0] right_ticks;
  logic [COUNT_BITS-1:0] left_ticks;
  logic [COUNT_BITS-1:0] right_len;
  logic [COUNT_BITS-1:0] left_len;
  logic [7:0]            high_z_run;

  result_t expected_words[$];
  result_t got_word;
  result_t want_word;
  int      fault_count = 0;
  int      pending_count = 0;

  assign mismatch_total  = fault_count;
  assign words_in_flight = pending_count;

  // A count triggers the image when it sits halfway through the part of the
  // last period that the image columns do not take up.
  function automatic logic at_trigger_point(input logic [COUNT_BITS-1:0] ticks,
                                            input logic [COUNT_BITS-1:0] len);
    logic [COUNT_BITS:0] offset;
    logic [COUNT_BITS:0] span;
    offset = (COUNT_BITS+1)'({columns, 1'b0});
    span   = {1'b0, len};
    if (span < offset) return 1'b0;
    return {1'b0, ticks} == ((span - offset) >> 1);
  endfunction

  // Advance the swing state by one sample and return the word it produces.
  function automatic result_t next_result(input logic signed [7:0] x,
                                          input logic signed [7:0] z);
    result_t r;
    r = '0;

    // Right swing starts on a falling crossing of the upper level.
    if (x < upper_level && last_x >= upper_level) begin
      right_ticks = '0;
      right_on = 1'b1;
    end else if (x < lower_level) begin
      right_on = 1'b0;
    end
    if (right_on) begin
      right_ticks = right_ticks + COUNT_BITS'(1);
      if (at_trigger_point(right_ticks, right_len)) r.show_image = 1'b1;
    end

    // Left swing starts on a rising crossing of the lower level.
    if (x > lower_level && last_x <= lower_level) begin
      left_ticks = '0;
      left_on = 1'b1;
    end else if (x > upper_level) begin
      left_on = 1'b0;
    end
    if (left_on) begin
      left_ticks = left_ticks + COUNT_BITS'(1);
      if (at_trigger_point(left_ticks, left_len)) r.show_image = 1'b1;
    end

    last_x = x;

    // While idle, a run of high z samples pulses the mode change.
    if (right_ticks > idle_limit || left_ticks > idle_limit) begin
      r.idle = 1'b1;
      if (z >= z_level) begin
        high_z_run = high_z_run + 8'd1;
        if (high_z_run == z_run_target) r.change_mode = 1'b1;
      end else begin
        high_z_run = '0;
      end
    end

    // A stopped count becomes the period of its direction.
    if (!right_on && right_ticks != '0) begin
      right_len = right_ticks;
      right_ticks = '0;
    end
    if (!left_on && left_ticks != '0) begin
      left_len = left_ticks;
      left_ticks = '0;
    end

    r.swing_right = right_on;
    r.swing_left  = left_on;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      upper_level  = UPPER_THRESHOLD_RESET;
      lower_level  = LOWER_THRESHOLD_RESET;
      idle_limit   = IDLE_LIMIT_RESET;
      columns      = IMAGE_COLUMNS_RESET;
      z_level      = MODE_Z_THRESHOLD_RESET;
      z_run_target = MODE_Z_RUN_RESET;
      last_x       = '0;
      right_on     = 1'b0;
      left_on      = 1'b1;
      right_ticks  = '0;
      left_ticks   = COUNT_BITS'(32'(IDLE_LIMIT_RESET) + 32'd1);
      right_len    = '0;
      left_len     = '0;
      high_z_run   = '0;
      expected_words.delete();
    end else begin
      // Register writes take effect at the access cycle.
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[4:2]))
          REG_UPPER_THRESHOLD:  upper_level  = pwdata[7:0];
          REG_LOWER_THRESHOLD:  lower_level  = pwdata[7:0];
          REG_IDLE_LIMIT:       idle_limit   = pwdata[15:0];
          REG_IMAGE_COLUMNS:    columns      = pwdata[7:0];
          REG_MODE_Z_THRESHOLD: z_level      = pwdata[7:0];
          REG_MODE_Z_RUN:       z_run_target = pwdata[7:0];
          default: ;
        endcase
      end

      // Each output word is compared with the oldest prediction. Words are
      // printed as show, right, left, idle, mode from the left.
      if (out_valid && out_ready) begin
        got_word = {show_image, swing_right, swing_left, idle, change_mode};
        if (expected_words.size() == 0) begin
          if (fault_count < 10)
            $display("%0t: result word %05b with nothing expected", $time, got_word);
          fault_count++;
        end else begin
          want_word = expected_words.pop_front();
          if (got_word !== want_word) begin
            if (fault_count < 10)
              $display("%0t: word mismatch, expected %05b, got %05b",
                       $time, want_word, got_word);
            fault_count++;
          end
        end
      end

      if (in_valid && in_ready)
        expected_words.push_back(next_result(accel_x, accel_z));
    end
    pending_count = expected_words.size();
  end

endmodule

>>> tb/swipe_period_image_trigger_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// swipe_period_image_trigger_tb: stimulus and verdict for the swipe trigger
// Sends directed and random x/z sample words through the block, mostly as
// well-formed back-and-forth swings, with random gaps on both channels and
// one long output stall. The thresholds are reprogrammed between phases,
// extremes included. The checker beside the block predicts and compares.
// ============================================================================
module swipe_period_image_trigger_tb;
  import spit_pkg::*;

  localparam int STALL_HOLD     = 80;
  localparam int WATCHDOG_LIMIT = 1000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [4:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic signed [7:0] accel_x = '0;
  logic signed [7:0] accel_z = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              show_image;
  logic              swing_right;
  logic              swing_left;
  logic              idle;
  logic              change_mode;

  int check_failures;
  int words_in_flight;
  int send_idle_pct = 10;
  int recv_idle_pct = 79;
  int quiet_cycles = 0;
  int swing_min = 8;
  int swing_max = 40;
  bit long_stall_req = 1'b0;

  // Current settings, used to shape the swings.
  logic signed [7:0] cur_upper   = UPPER_THRESHOLD_RESET;
  logic signed [7:0] cur_lower   = LOWER_THRESHOLD_RESET;
  logic signed [7:0] cur_z_level = MODE_Z_THRESHOLD_RESET;

  always #2 clk = ~clk;

  swipe_period_image_trigger DUT (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .accel_x     (accel_x),
    .accel_z     (accel_z),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .show_image  (show_image),
    .swing_right (swing_right),
    .swing_left  (swing_left),
    .idle        (idle),
    .change_mode (change_mode)
  );

  swing_trigger_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .accel_x         (accel_x),
    .accel_z         (accel_z),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .show_image      (show_image),
    .swing_right     (swing_right),
    .swing_left      (swing_left),
    .idle            (idle),
    .change_mode     (change_mode),
    .mismatch_total  (check_failures),
    .words_in_flight (words_in_flight)
  );

  // Receiver: random ready, and one long hold-off when asked for.
  initial begin
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        out_ready <= 1'b0;
        repeat (STALL_HOLD) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic logic signed [7:0] draw_level(input int lo, input int hi);
    return 8'($urandom_range(hi - lo) + lo);
  endfunction

  // Mostly z at or above the mode level, so that runs build up.
  function automatic logic signed [7:0] draw_z();
    if ($urandom_range(9) < 7) return draw_level(cur_z_level, 127);
    return draw_level(-128, 127);
  endfunction

  // Offer one word, idling at random first, and wait until it is taken.
  task automatic send_word(input logic signed [7:0] x_level,
                           input logic signed [7:0] z_level);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    accel_x  <= x_level;
    accel_z  <= z_level;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_level_run(input int lo, input int hi, input int n_words);
    repeat (n_words) send_word(draw_level(lo, hi), draw_z());
  endtask

  task automatic send_noise(input int n_words);
    repeat (n_words) send_word(draw_level(-128, 127), draw_level(-128, 127));
  endtask

  // Back-and-forth swings with random content, broken now and then.
  task automatic send_swing_run(input int n_words);
    int sent;
    int leg_len;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(99) < 15) begin
        send_word(draw_level(-128, 127), draw_level(-128, 127));
        sent++;
      end else begin
        // Above the upper level, then falling through the middle.
        leg_len = $urandom_range(2, 1);
        send_level_run(cur_upper + 1, 127, leg_len);
        sent += leg_len;
        leg_len = $urandom_range(swing_max, swing_min);
        send_level_run(cur_lower + 1, cur_upper - 1, leg_len);
        sent += leg_len;
        // Below the lower level, skipped now and then, then rising back.
        if ($urandom_range(9) != 0) begin
          leg_len = $urandom_range(2, 1);
          send_level_run(-128, cur_lower - 1, leg_len);
          sent += leg_len;
        end
        leg_len = $urandom_range(swing_max, swing_min);
        send_level_run(cur_lower + 1, cur_upper - 1, leg_len);
        sent += leg_len;
      end
    end
  endtask

  // One APB write: setup cycle, access cycle, then the bus is released.
  task automatic write_register(input reg_index_t index, input logic [15:0] value);
    logic [31:0] bus_word;
    bus_word = $urandom;
    if (index == REG_IDLE_LIMIT) bus_word[15:0] = value;
    else bus_word[7:0] = value[7:0];
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= bus_word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_settings(input int upper, input int lower, input int limit,
                                input int cols, input int z_lvl, input int z_run);
    write_register(REG_UPPER_THRESHOLD, 16'(upper));
    write_register(REG_LOWER_THRESHOLD, 16'(lower));
    write_register(REG_IDLE_LIMIT, 16'(limit));
    write_register(REG_IMAGE_COLUMNS, 16'(cols));
    write_register(REG_MODE_Z_THRESHOLD, 16'(z_lvl));
    write_register(REG_MODE_Z_RUN, 16'(z_run));
    cur_upper   = 8'(upper);
    cur_lower   = 8'(lower);
    cur_z_level = 8'(z_lvl);
  endtask

  // Stop offering words and wait until every predicted word has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_in_flight != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed words at the reset settings. The left count starts beyond
    // the idle limit, so a run of high z gives a mode change at once.
    repeat (10) send_word(8'sd0, 8'sd127);
    send_word(8'sd0, 8'sd99);
    send_word(8'sd0, 8'sd100);
    send_word(8'sd127, -8'sd128);
    send_word(8'sd126, 8'sd0);
    send_word(8'sd125, 8'sd0);
    send_word(-8'sd127, 8'sd0);
    send_word(-8'sd126, 8'sd0);
    send_word(-8'sd125, 8'sd0);
    send_word(-8'sd128, 8'sd127);
    send_word(-8'sd128, -8'sd128);
    send_word(8'sd127, 8'sd0);
    wait_for_results();

    // Moderate levels, swings long enough to go idle, one long output stall.
    write_settings(40, -40, 45, 5, 60, 5);
    swing_min = 12;
    swing_max = 60;
    send_swing_run(200);
    long_stall_req = 1'b1;
    send_swing_run(350);
    wait_for_results();

    // Swap the idling of the two sides; both levels above zero.
    send_idle_pct = 79;
    recv_idle_pct = 10;
    write_settings(100, 10, 40, 3, 20, 3);
    swing_min = 8;
    swing_max = 30;
    send_swing_run(450);
    wait_for_results();

    // Widest levels, zero idle limit, every z counts, longest run target.
    write_settings(127, -128, 0, 255, -128, 255);
    send_noise(300);
    wait_for_results();

    // Inverted levels and the other extremes, with no idling from here on.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_settings(-128, 127, 65535, 1, 127, 1);
    send_noise(150);
    wait_for_results();

    // Zero columns and a zero run target: the z run must wrap to pulse.
    write_settings(50, -50, 10, 0, 0, 0);
    swing_min = 6;
    swing_max = 24;
    send_swing_run(100);
    send_word(8'sd100, 8'sd0);
    send_word(8'sd0, 8'sd0);
    repeat (300) send_word(draw_level(-49, 49), draw_level(0, 127));
    wait_for_results();

    // A right period of two gives a target of zero, which a running right
    // count does not reach, so the following swing shows nothing early.
    write_settings(60, -60, 1000, 1, 127, 200);
    send_word(8'sd100, 8'sd0);
    send_word(8'sd0, 8'sd0);
    send_word(8'sd0, 8'sd0);
    send_word(-8'sd100, 8'sd0);
    send_word(8'sd0, 8'sd0);
    send_word(8'sd100, 8'sd0);
    send_word(8'sd0, 8'sd0);
    send_level_run(-59, 59, 40);
    send_word(-8'sd100, 8'sd0);
    swing_min = 4;
    swing_max = 16;
    send_swing_run(60);
    wait_for_results();

    repeat (8) @(posedge clk);
    if (check_failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/spit_pkg.sv
src/spit_cfg_regs.sv
src/spit_core.sv
src/swipe_period_image_trigger.sv
tb/swing_trigger_checker.sv
tb/swipe_period_image_trigger_tb.sv
